FILE: rtl/core/rbs_pkg.sv
// Shared types, constants and widths for the RGB bilinear sampler.
// Used by every module under rtl/core but rbs_ram; depends on nothing else.
`default_nettype none

package rbs_pkg;

  // Pixel memory geometry.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;

  localparam int XIW   = $clog2(MAX_WIDTH);
  localparam int YIW   = $clog2(MAX_HEIGHT);
  localparam int IW    = (XIW > YIW) ? XIW : YIW;
  localparam int CW    = IW + FRAC_BITS;
  localparam int POS_W = 18;
  localparam int MW    = (CW > POS_W - 1) ? CW : POS_W - 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  localparam int SIZE_W = 9;
  localparam int COORD_W = 8;
  localparam int CHAN_W = 16;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int WGT_W  = 2 * FRAC_BITS - 1;
  localparam int PROD_W = WGT_W + CHAN_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic [ACC_W-1:0]  ROUND_BIAS = ACC_W'(16384);
  localparam int                RES_SHIFT  = 15;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  // Twelve neighbour reads per sample: three channels of four.
  localparam int               NSTEP     = 12;
  localparam int               STEP_W    = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEP - 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Channel codes.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } back_state_e;

  // Neighbour indexes and fractions of one channel's sample position.
  typedef struct packed {
    logic [XIW-1:0]       ix;
    logic [XIW-1:0]       nx;
    logic [YIW-1:0]       iy;
    logic [YIW-1:0]       ny;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } chan_pos_t;

  typedef struct packed {
    op_e                  op;
    logic                 wen;
    logic [AW-1:0]        waddr;
    logic [PIX_W-1:0]     wdata;
    chan_pos_t [2:0]      pos;
  } cmd_t;

  typedef struct packed {
    logic                 first;
    logic                 last;
    logic [1:0]           ch;
    logic [WGT_W-1:0]     weight;
  } stage2_t;

  typedef struct packed {
    logic                 first;
    logic                 last;
    logic [1:0]           ch;
    logic [PROD_W-1:0]    prod;
  } stage3_t;

endpackage

`default_nettype wire

FILE: rtl/core/rgb_bilinear_sampler_unit.sv
// RGB bilinear sampler, top level. Each accepted item is decoded by the
// front end, held in a two-entry command queue and executed by the back end.
// A sample reads twelve neighbour words through the single read port of the
// pixel memory, one per cycle, and its result passes the product and
// accumulate registers into the output registers; a new sample starts only
// after the previous result has been transferred. Pixels must be written
// before they are sampled: the memory is not cleared by reset. Width and
// height registers must be written only while the block is idle; this binds
// the user, and the block itself does not enforce it.
// Depends on rbs_pkg, rbs_front, rbs_queue, rbs_back and rbs_ram.
`default_nettype none

module rgb_bilinear_sampler_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [rbs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [rbs_pkg::SIZE_W-1:0]       cfg_data_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_ready_o,
  input  wire logic                             op_i,
  input  wire logic [rbs_pkg::COORD_W-1:0]      write_x_i,
  input  wire logic [rbs_pkg::COORD_W-1:0]      write_y_i,
  input  wire logic [rbs_pkg::CHAN_W-1:0]       write_red_i,
  input  wire logic [rbs_pkg::CHAN_W-1:0]       write_green_i,
  input  wire logic [rbs_pkg::CHAN_W-1:0]       write_blue_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0] red_pos_x_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0] red_pos_y_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0] green_pos_x_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0] green_pos_y_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0] blue_pos_x_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0] blue_pos_y_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic [rbs_pkg::CHAN_W-1:0]       out_red_o,
  output      logic [rbs_pkg::CHAN_W-1:0]       out_green_o,
  output      logic [rbs_pkg::CHAN_W-1:0]       out_blue_o
);

  logic          q_full;
  logic          push;
  rbs_pkg::cmd_t push_cmd;
  logic          pop;
  logic          head_valid;
  rbs_pkg::cmd_t head;

  rbs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .write_x_i     (write_x_i),
    .write_y_i     (write_y_i),
    .write_red_i   (write_red_i),
    .write_green_i (write_green_i),
    .write_blue_i  (write_blue_i),
    .red_pos_x_i   (red_pos_x_i),
    .red_pos_y_i   (red_pos_y_i),
    .green_pos_x_i (green_pos_x_i),
    .green_pos_y_i (green_pos_y_i),
    .blue_pos_x_i  (blue_pos_x_i),
    .blue_pos_y_i  (blue_pos_y_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  rbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  rbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the pixel memory of the sampler.
`default_nettype none

module rbs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/rbs_front.sv
// Front end: configuration registers, input acceptance and item decode.
// Clamps sample positions and splits them into neighbours; uses rbs_pkg.
`default_nettype none

module rbs_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [rbs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [rbs_pkg::SIZE_W-1:0]          cfg_data_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic                                op_i,
  input  wire logic [rbs_pkg::COORD_W-1:0]         write_x_i,
  input  wire logic [rbs_pkg::COORD_W-1:0]         write_y_i,
  input  wire logic [rbs_pkg::CHAN_W-1:0]          write_red_i,
  input  wire logic [rbs_pkg::CHAN_W-1:0]          write_green_i,
  input  wire logic [rbs_pkg::CHAN_W-1:0]          write_blue_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0]    red_pos_x_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0]    red_pos_y_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0]    green_pos_x_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0]    green_pos_y_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0]    blue_pos_x_i,
  input  wire logic signed [rbs_pkg::POS_W-1:0]    blue_pos_y_i,
  input  wire logic                                q_full_i,
  output      logic                                push_o,
  output      rbs_pkg::cmd_t                       cmd_o
);

  logic [rbs_pkg::SIZE_W-1:0] width_q;
  logic [rbs_pkg::SIZE_W-1:0] height_q;
  logic [rbs_pkg::IW-1:0]     last_x;
  logic [rbs_pkg::IW-1:0]     last_y;
  logic signed [rbs_pkg::POS_W-1:0] pos_x [3];
  logic signed [rbs_pkg::POS_W-1:0] pos_y [3];
  logic [rbs_pkg::CW-1:0]     cx [3];
  logic [rbs_pkg::CW-1:0]     cy [3];
  logic [rbs_pkg::IW-1:0]     ix [3];
  logic [rbs_pkg::IW-1:0]     iy [3];
  logic [rbs_pkg::IW-1:0]     nx [3];
  logic [rbs_pkg::IW-1:0]     ny [3];

  // Size register to last valid index; zero acts as one, oversize saturates.
  function automatic logic [rbs_pkg::IW-1:0] last_index(
    input logic [rbs_pkg::SIZE_W-1:0] size,
    input int                         maxv
  );
    if (size == '0) begin
      last_index = '0;
    end else if (32'(size) > maxv) begin
      last_index = rbs_pkg::IW'(maxv - 1);
    end else begin
      last_index = rbs_pkg::IW'(size - rbs_pkg::SIZE_W'(1));
    end
  endfunction

  function automatic logic [rbs_pkg::CW-1:0] clamp_coord(
    input logic signed [rbs_pkg::POS_W-1:0] p,
    input logic [rbs_pkg::IW-1:0]           last
  );
    logic [rbs_pkg::CW-1:0] top;
    logic [rbs_pkg::MW-1:0] pu;
    logic [rbs_pkg::MW-1:0] tw;
    top = rbs_pkg::CW'(last) << rbs_pkg::FRAC_BITS;
    pu  = rbs_pkg::MW'(p[rbs_pkg::POS_W-2:0]);
    tw  = rbs_pkg::MW'(top);
    if (p[rbs_pkg::POS_W-1]) begin
      clamp_coord = '0;
    end else if (pu > tw) begin
      clamp_coord = top;
    end else begin
      clamp_coord = rbs_pkg::CW'(pu);
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rbs_pkg::SIZE_RESET;
      height_q <= rbs_pkg::SIZE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rbs_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        rbs_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && !q_full_i;

  assign last_x = last_index(width_q, rbs_pkg::MAX_WIDTH);
  assign last_y = last_index(height_q, rbs_pkg::MAX_HEIGHT);

  assign pos_x[0] = red_pos_x_i;
  assign pos_y[0] = red_pos_y_i;
  assign pos_x[1] = green_pos_x_i;
  assign pos_y[1] = green_pos_y_i;
  assign pos_x[2] = blue_pos_x_i;
  assign pos_y[2] = blue_pos_y_i;

  always_comb begin
    cmd_o.op    = rbs_pkg::op_e'(op_i);
    cmd_o.wen   = (32'(write_x_i) < rbs_pkg::MAX_WIDTH) &&
                  (32'(write_y_i) < rbs_pkg::MAX_HEIGHT);
    cmd_o.waddr = rbs_pkg::AW'(rbs_pkg::AW'(write_y_i) * rbs_pkg::AW'(rbs_pkg::MAX_WIDTH)
                  + rbs_pkg::AW'(write_x_i));
    cmd_o.wdata = {write_blue_i, write_green_i, write_red_i};
    for (int c = 0; c < 3; c++) begin
      cx[c] = clamp_coord(pos_x[c], last_x);
      cy[c] = clamp_coord(pos_y[c], last_y);
      ix[c] = cx[c][rbs_pkg::CW-1:rbs_pkg::FRAC_BITS];
      iy[c] = cy[c][rbs_pkg::CW-1:rbs_pkg::FRAC_BITS];
      // The integer part never exceeds the last index, so this is the edge clamp.
      nx[c] = (ix[c] == last_x) ? ix[c] : ix[c] + rbs_pkg::IW'(1);
      ny[c] = (iy[c] == last_y) ? iy[c] : iy[c] + rbs_pkg::IW'(1);
      cmd_o.pos[c].ix = rbs_pkg::XIW'(ix[c]);
      cmd_o.pos[c].nx = rbs_pkg::XIW'(nx[c]);
      cmd_o.pos[c].iy = rbs_pkg::YIW'(iy[c]);
      cmd_o.pos[c].ny = rbs_pkg::YIW'(ny[c]);
      cmd_o.pos[c].fx = cx[c][rbs_pkg::FRAC_BITS-1:0];
      cmd_o.pos[c].fy = cy[c][rbs_pkg::FRAC_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rbs_queue.sv
// Short command queue between the front end and the back end.
// Holds decoded commands of type rbs_pkg::cmd_t.
`default_nettype none

module rbs_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rbs_pkg::cmd_t cmd_i,
  output      logic          full_o,
  input  wire logic          pop_i,
  output      logic          valid_o,
  output      rbs_pkg::cmd_t head_o
);

  rbs_pkg::cmd_t              slot_q [rbs_pkg::QDEPTH];
  logic [rbs_pkg::QPTR_W-1:0] wr_ptr_q;
  logic [rbs_pkg::QPTR_W-1:0] rd_ptr_q;
  logic [rbs_pkg::QCNT_W-1:0] count_q;

  function automatic logic [rbs_pkg::QPTR_W-1:0] next_ptr(
    input logic [rbs_pkg::QPTR_W-1:0] p
  );
    if (32'(p) == rbs_pkg::QDEPTH - 1) begin
      next_ptr = '0;
    end else begin
      next_ptr = p + rbs_pkg::QPTR_W'(1);
    end
  endfunction

  assign full_o  = (count_q == rbs_pkg::QCNT_W'(rbs_pkg::QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + rbs_pkg::QCNT_W'(1);
        2'b01:   count_q <= count_q - rbs_pkg::QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rbs_pkg::QCNT_W'(rbs_pkg::QDEPTH))
    else $error("command queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i) |=> (count_q == $past(count_q) - rbs_pkg::QCNT_W'(1)))
    else $error("command queue pop lost");

endmodule

`default_nettype wire

FILE: rtl/core/rbs_back.sv
// Back end: executes pixel writes and runs the twelve-read interpolation.
// Uses rbs_pkg and one rbs_ram instance for the pixel memory.
`default_nettype none

module rbs_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          head_valid_i,
  input  wire rbs_pkg::cmd_t                 head_i,
  output      logic                          pop_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [rbs_pkg::CHAN_W-1:0]    out_red_o,
  output      logic [rbs_pkg::CHAN_W-1:0]    out_green_o,
  output      logic [rbs_pkg::CHAN_W-1:0]    out_blue_o
);

  rbs_pkg::back_state_e       state_q, state_d;
  logic [rbs_pkg::STEP_W-1:0] step_q, step_d;
  rbs_pkg::cmd_t              cmd_q, cmd_d;
  logic                       issue;
  logic                       busy;
  logic                       ram_we;
  logic [rbs_pkg::AW-1:0]     raddr;
  logic [rbs_pkg::PIX_W-1:0]  rdata;

  logic [1:0]                 cur_ch;
  logic [1:0]                 cur_nb;
  rbs_pkg::chan_pos_t         cur_pos;
  logic [rbs_pkg::XIW-1:0]    col;
  logic [rbs_pkg::YIW-1:0]    row;
  logic [rbs_pkg::FRAC_BITS-1:0] wa;
  logic [rbs_pkg::FRAC_BITS-1:0] wb;
  logic [2*rbs_pkg::FRAC_BITS-1:0] wprod;

  logic                       s2_v_q;
  rbs_pkg::stage2_t           s2_q;
  logic                       s3_v_q;
  rbs_pkg::stage3_t           s3_q;
  logic [rbs_pkg::CHAN_W-1:0] sel_data;
  logic [rbs_pkg::ACC_W-1:0]  acc_q;
  logic [rbs_pkg::ACC_W-1:0]  acc_sum;
  logic [rbs_pkg::CHAN_W-1:0] result;
  logic                       out_valid_q;
  logic [rbs_pkg::CHAN_W-1:0] out_red_q;
  logic [rbs_pkg::CHAN_W-1:0] out_green_q;
  logic [rbs_pkg::CHAN_W-1:0] out_blue_q;

  // A new sample starts only once the previous result has been transferred,
  // since the result lands directly in the output registers.
  assign busy = out_valid_q || s2_v_q || s3_v_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_d   = cmd_q;
    pop_o   = 1'b0;
    ram_we  = 1'b0;
    issue   = 1'b0;
    case (state_q)
      rbs_pkg::ST_IDLE: begin
        if (head_valid_i) begin
          if (head_i.op == rbs_pkg::OP_WRITE) begin
            pop_o  = 1'b1;
            ram_we = head_i.wen;
          end else if (!busy) begin
            pop_o   = 1'b1;
            cmd_d   = head_i;
            step_d  = '0;
            state_d = rbs_pkg::ST_RUN;
          end
        end
      end
      rbs_pkg::ST_RUN: begin
        issue  = 1'b1;
        step_d = step_q + rbs_pkg::STEP_W'(1);
        if (step_q == rbs_pkg::LAST_STEP) begin
          state_d = rbs_pkg::ST_IDLE;
        end
      end
      default: state_d = rbs_pkg::ST_IDLE;
    endcase
  end

  // Step decode: upper bits pick the channel, lower bits the neighbour
  // (a, b, c, d = top-left, top-right, bottom-left, bottom-right).
  assign cur_ch = step_q[3:2];
  assign cur_nb = step_q[1:0];

  always_comb begin
    case (cur_ch)
      rbs_pkg::CH_RED:   cur_pos = cmd_q.pos[0];
      rbs_pkg::CH_GREEN: cur_pos = cmd_q.pos[1];
      default:           cur_pos = cmd_q.pos[2];
    endcase
    col   = cur_nb[0] ? cur_pos.nx : cur_pos.ix;
    row   = cur_nb[1] ? cur_pos.ny : cur_pos.iy;
    wa    = cur_nb[0] ? cur_pos.fx : ~cur_pos.fx;
    wb    = cur_nb[1] ? cur_pos.fy : ~cur_pos.fy;
    wprod = (2*rbs_pkg::FRAC_BITS)'(wa) * (2*rbs_pkg::FRAC_BITS)'(wb);
    raddr = rbs_pkg::AW'(rbs_pkg::AW'(row) * rbs_pkg::AW'(rbs_pkg::MAX_WIDTH)
            + rbs_pkg::AW'(col));
  end

  rbs_ram #(
    .WIDTH (rbs_pkg::PIX_W),
    .DEPTH (rbs_pkg::DEPTH)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.waddr),
    .wdata_i (head_i.wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    case (s2_q.ch)
      rbs_pkg::CH_RED:   sel_data = rdata[rbs_pkg::CHAN_W-1:0];
      rbs_pkg::CH_GREEN: sel_data = rdata[2*rbs_pkg::CHAN_W-1:rbs_pkg::CHAN_W];
      default:           sel_data = rdata[3*rbs_pkg::CHAN_W-1:2*rbs_pkg::CHAN_W];
    endcase
  end

  assign acc_sum = (s3_q.first ? rbs_pkg::ROUND_BIAS : acc_q) + rbs_pkg::ACC_W'(s3_q.prod);
  assign result  = acc_sum[rbs_pkg::RES_SHIFT +: rbs_pkg::CHAN_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbs_pkg::ST_IDLE;
      step_q      <= '0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      s2_v_q  <= issue;
      s3_v_q  <= s2_v_q;
      if (s3_v_q && s3_q.last && (s3_q.ch == rbs_pkg::CH_BLUE)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    s2_q.first  <= (cur_nb == 2'd0);
    s2_q.last   <= (cur_nb == 2'd3);
    s2_q.ch     <= cur_ch;
    s2_q.weight <= wprod[2*rbs_pkg::FRAC_BITS-1:1];
    s3_q.first  <= s2_q.first;
    s3_q.last   <= s2_q.last;
    s3_q.ch     <= s2_q.ch;
    s3_q.prod   <= rbs_pkg::PROD_W'(s2_q.weight) * rbs_pkg::PROD_W'(sel_data);
    if (s3_v_q) begin
      acc_q <= acc_sum;
      if (s3_q.last) begin
        case (s3_q.ch)
          rbs_pkg::CH_RED:   out_red_q   <= result;
          rbs_pkg::CH_GREEN: out_green_q <= result;
          default:           out_blue_q  <= result;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_red_q;
  assign out_green_o = out_green_q;
  assign out_blue_o  = out_blue_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbs_pkg::ST_RUN) |-> !ram_we)
    else $error("pixel write during a sample read sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s3_v_q && s3_q.last && (s3_q.ch == rbs_pkg::CH_BLUE)))
    else $error("result raised before the last blue term");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |-> $past(s2_v_q))
    else $error("accumulate stage valid without a product stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

`default_nettype wire

FILE: dv/rgb_bilinear_sampler_unit_tb.sv
// Self-checking testbench for the RGB bilinear sampler: pixel writes, samples
// with clamping at every edge, and size settings swept across their range.
// Depends on rbs_pkg and rgb_bilinear_sampler_unit, and through it on the rest of rtl/core.
`default_nettype none

module rgb_bilinear_sampler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbs_pkg::*;

  localparam int LIMIT_CYCLES    = 300000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 64;
  localparam int FIXED_PHASES    = 7;

  // Size settings of the first phases; the later ones are random.
  localparam logic [SIZE_W-1:0] FIXED_W [FIXED_PHASES] =
    '{9'd1, 9'd0, 9'd256, 9'd511, 9'd2, 9'd257, 9'd3};
  localparam logic [SIZE_W-1:0] FIXED_H [FIXED_PHASES] =
    '{9'd1, 9'd256, 9'd0, 9'd300, 9'd2, 9'd1, 9'd5};

  // pos holds red x, red y, green x, green y, blue x, blue y in that order.
  typedef struct packed {
    op_e                   op;
    logic [COORD_W-1:0]    wx;
    logic [COORD_W-1:0]    wy;
    logic [CHAN_W-1:0]     wr;
    logic [CHAN_W-1:0]     wg;
    logic [CHAN_W-1:0]     wb;
    logic [5:0][POS_W-1:0] pos;
  } sampler_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    sampler_item_t item;
    logic          typed;
    rgb_t          want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                       cfg_valid_i   = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i   = REG_WIDTH;
  logic [SIZE_W-1:0]          cfg_data_i    = '0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_ready_o;
  logic                       op_i          = OP_WRITE;
  logic [COORD_W-1:0]         write_x_i     = '0;
  logic [COORD_W-1:0]         write_y_i     = '0;
  logic [CHAN_W-1:0]          write_red_i   = '0;
  logic [CHAN_W-1:0]          write_green_i = '0;
  logic [CHAN_W-1:0]          write_blue_i  = '0;
  logic signed [POS_W-1:0]    red_pos_x_i   = '0;
  logic signed [POS_W-1:0]    red_pos_y_i   = '0;
  logic signed [POS_W-1:0]    green_pos_x_i = '0;
  logic signed [POS_W-1:0]    green_pos_y_i = '0;
  logic signed [POS_W-1:0]    blue_pos_x_i  = '0;
  logic signed [POS_W-1:0]    blue_pos_y_i  = '0;
  logic                       out_valid_o;
  logic                       out_ready_i   = 1'b0;
  logic [CHAN_W-1:0]          out_red_o;
  logic [CHAN_W-1:0]          out_green_o;
  logic [CHAN_W-1:0]          out_blue_o;

  // Shadow of the pixel memory and of the sizes in use.
  logic [PIX_W-1:0] pix_mem [DEPTH];
  bit               written [DEPTH];
  int               img_w = MAX_WIDTH;
  int               img_h = MAX_HEIGHT;

  rgb_t pending_rgb_q [$];
  int   errors     = 0;
  int   stall_left = 0;
  bit   no_idle    = 1'b0;

  rgb_bilinear_sampler_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .write_x_i     (write_x_i),
    .write_y_i     (write_y_i),
    .write_red_i   (write_red_i),
    .write_green_i (write_green_i),
    .write_blue_i  (write_blue_i),
    .red_pos_x_i   (red_pos_x_i),
    .red_pos_y_i   (red_pos_y_i),
    .green_pos_x_i (green_pos_x_i),
    .green_pos_y_i (green_pos_y_i),
    .blue_pos_x_i  (blue_pos_x_i),
    .blue_pos_y_i  (blue_pos_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int clamp_coord(input logic [POS_W-1:0] p, input int s);
    int v;
    v = $signed(p);
    if (v > ((s - 1) << FRAC_BITS)) v = (s - 1) << FRAC_BITS;
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic logic [CHAN_W-1:0] texel(input int x, input int y, input int ch);
    return pix_mem[y * MAX_WIDTH + x][ch * CHAN_W +: CHAN_W];
  endfunction

  // Weights use 255 rather than 256, so a flat image comes out slightly darker.
  function automatic logic [CHAN_W-1:0] bilinear_channel(input logic [POS_W-1:0] pos_x,
                                                         input logic [POS_W-1:0] pos_y,
                                                         input int ch);
    int          cx, cy, ix, iy, nx, ny, fx, fy;
    logic [63:0] acc;
    cx = clamp_coord(pos_x, img_w);
    cy = clamp_coord(pos_y, img_h);
    ix = cx >> FRAC_BITS;
    iy = cy >> FRAC_BITS;
    fx = cx & 255;
    fy = cy & 255;
    nx = (ix + 1 > img_w - 1) ? img_w - 1 : ix + 1;
    ny = (iy + 1 > img_h - 1) ? img_h - 1 : iy + 1;
    acc = 64'(((255 - fx) * (255 - fy)) >> 1) * texel(ix, iy, ch)
        + 64'((fx * (255 - fy)) >> 1) * texel(nx, iy, ch)
        + 64'(((255 - fx) * fy) >> 1) * texel(ix, ny, ch)
        + 64'((fx * fy) >> 1) * texel(nx, ny, ch)
        + 64'(16384);
    return CHAN_W'(acc >> 15);
  endfunction

  function automatic sampler_item_t random_item();
    sampler_item_t it;
    it.op = OP_WRITE;
    it.wx = COORD_W'($urandom);
    it.wy = COORD_W'($urandom);
    it.wr = CHAN_W'($urandom);
    it.wg = CHAN_W'($urandom);
    it.wb = CHAN_W'($urandom);
    for (int k = 0; k < 6; k++) it.pos[k] = POS_W'($urandom);
    return it;
  endfunction

  function automatic dir_row_t write_row(input int x, input int y, input logic [CHAN_W-1:0] r,
                                         input logic [CHAN_W-1:0] g,
                                         input logic [CHAN_W-1:0] b);
    dir_row_t row;
    row.item    = random_item();
    row.item.wx = COORD_W'(x);
    row.item.wy = COORD_W'(y);
    row.item.wr = r;
    row.item.wg = g;
    row.item.wb = b;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic dir_row_t sample_row(input logic [POS_W-1:0] rx, ry, gx, gy, bx, by,
                                          input logic typed,
                                          input logic [CHAN_W-1:0] er, eg, eb);
    dir_row_t row;
    row.item        = random_item();
    row.item.op     = OP_SAMPLE;
    row.item.pos    = {by, bx, gy, gx, ry, rx};
    row.typed       = typed;
    row.want.red    = er;
    row.want.green  = eg;
    row.want.blue   = eb;
    return row;
  endfunction

  function automatic logic [SIZE_W-1:0] random_size();
    case ($urandom_range(0, 2))
      0: return SIZE_W'($urandom_range(1, 8));
      1: return SIZE_W'($urandom_range(1, 256));
      default: return SIZE_W'($urandom_range(0, 511));
    endcase
  endfunction

  // Picks the pixel indexes of one axis that get written in a phase: both ends
  // plus a band of four. An index is safe to sample when it and its right or
  // lower neighbour are both in the set.
  function automatic void build_axis(input int s, ref int members[$], ref int safe[$]);
    bit in_set [MAX_WIDTH];
    int b;
    members.delete();
    safe.delete();
    b = $urandom_range(0, s - 1);
    for (int i = 0; i < s; i++)
      in_set[i] = (i <= 1) || (i >= s - 2) || (i >= b && i <= b + 3);
    for (int i = 0; i < s; i++) begin
      if (in_set[i]) begin
        members.push_back(i);
        if (in_set[(i + 1 < s) ? i + 1 : s - 1]) safe.push_back(i);
      end
    end
  endfunction

  function automatic logic [POS_W-1:0] random_coord(input int s, input int safe[$]);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return POS_W'(-int'($urandom_range(1, 131072)));
    if (pick == 1) return POS_W'($urandom_range(((s - 1) << FRAC_BITS) + 1, 131071));
    return POS_W'(safe[$urandom_range(0, safe.size() - 1)] * 256 + $urandom_range(0, 255));
  endfunction

  task automatic write_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    for (int r = 0; r < 2; r++) begin
      cfg_index_i <= (r == 0) ? REG_WIDTH : REG_HEIGHT;
      cfg_data_i  <= (r == 0) ? w : h;
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      if (r == 0) img_w = clamp_size(w, MAX_WIDTH);
      else img_h = clamp_size(h, MAX_HEIGHT);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drive_item(input sampler_item_t it, input logic typed, input rgb_t want);
    rgb_t predicted;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    op_i          <= it.op;
    write_x_i     <= it.wx;
    write_y_i     <= it.wy;
    write_red_i   <= it.wr;
    write_green_i <= it.wg;
    write_blue_i  <= it.wb;
    red_pos_x_i   <= it.pos[0];
    red_pos_y_i   <= it.pos[1];
    green_pos_x_i <= it.pos[2];
    green_pos_y_i <= it.pos[3];
    blue_pos_x_i  <= it.pos[4];
    blue_pos_y_i  <= it.pos[5];
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.op == OP_WRITE) begin
      pix_mem[it.wy * MAX_WIDTH + it.wx] = {it.wb, it.wg, it.wr};
      written[it.wy * MAX_WIDTH + it.wx] = 1'b1;
    end else if (typed) begin
      pending_rgb_q.push_back(want);
    end else begin
      predicted.red   = bilinear_channel(it.pos[0], it.pos[1], CH_RED);
      predicted.green = bilinear_channel(it.pos[2], it.pos[3], CH_GREEN);
      predicted.blue  = bilinear_channel(it.pos[4], it.pos[5], CH_BLUE);
      pending_rgb_q.push_back(predicted);
    end
  endtask

  // Stops sending, lets every pending sample come back, then lets the
  // block finish any write still in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_rgb_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    rgb_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_rgb_q.size() == 0) begin
        $error("result with no sample pending: red %h green %h blue %h",
               out_red_o, out_green_o, out_blue_o);
        errors++;
      end else begin
        want = pending_rgb_q.pop_front();
        check_field("out_red", want.red, out_red_o);
        check_field("out_green", want.green, out_green_o);
        check_field("out_blue", want.blue, out_blue_o);
      end
    end
  end

  always @(posedge clk_i) begin : result_backpressure
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 4);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    dir_row_t          dir_rows [$];
    sampler_item_t     it;
    int                col_set [$];
    int                row_set [$];
    int                col_safe [$];
    int                row_safe [$];
    int                k;
    int                x;
    int                y;
    logic [SIZE_W-1:0] w_cfg;
    logic [SIZE_W-1:0] h_cfg;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners of the full 256 x 256 image, then samples at the extremes.
    dir_rows.push_back(write_row(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    dir_rows.push_back(write_row(1, 0, 16'h0000, 16'h0000, 16'h0000));
    dir_rows.push_back(write_row(0, 1, 16'h8000, 16'h00FF, 16'h7FFF));
    dir_rows.push_back(write_row(1, 1, 16'h1234, 16'h5678, 16'h9ABC));
    dir_rows.push_back(write_row(255, 255, 16'hFFFF, 16'h0000, 16'hFFFF));
    dir_rows.push_back(write_row(254, 255, 16'h0001, 16'hFFFE, 16'hAAAA));
    dir_rows.push_back(write_row(255, 254, 16'h5555, 16'h8001, 16'h0100));
    dir_rows.push_back(write_row(254, 254, 16'hC3C3, 16'h3C3C, 16'h0F0F));
    // A full-scale pixel read at zero fraction comes back as FDFF.
    dir_rows.push_back(sample_row(18'h00000, 18'h00000, 18'h00000, 18'h00000,
                                  18'h00000, 18'h00000, 1'b1, 16'hFDFF, 16'hFDFF, 16'hFDFF));
    dir_rows.push_back(sample_row(18'h20000, 18'h20000, 18'h20000, 18'h20000,
                                  18'h20000, 18'h20000, 1'b1, 16'hFDFF, 16'hFDFF, 16'hFDFF));
    dir_rows.push_back(sample_row(18'h1FFFF, 18'h1FFFF, 18'h00000, 18'h00000,
                                  18'h3FFFF, 18'h3FFFF, 1'b1, 16'hFDFF, 16'hFDFF, 16'hFDFF));
    dir_rows.push_back(sample_row(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
                                  18'h1FFFF, 18'h1FFFF, 1'b1, 16'hFDFF, 16'h0000, 16'hFDFF));
    dir_rows.push_back(sample_row(18'h0FF00, 18'h0FF00, 18'h0FF00, 18'h0FF00,
                                  18'h0FF00, 18'h0FF00, 1'b1, 16'hFDFF, 16'h0000, 16'hFDFF));
    dir_rows.push_back(sample_row(18'h00080, 18'h00080, 18'h00080, 18'h00080,
                                  18'h00080, 18'h00080, 1'b0, '0, '0, '0));
    dir_rows.push_back(sample_row(18'h000FF, 18'h000FF, 18'h000FF, 18'h000FF,
                                  18'h000FF, 18'h000FF, 1'b0, '0, '0, '0));
    dir_rows.push_back(sample_row(18'h0FE80, 18'h0FE80, 18'h0FE01, 18'h0FEFF,
                                  18'h0FFFF, 18'h0FE00, 1'b0, '0, '0, '0));
    dir_rows.push_back(sample_row(18'h00080, 18'h000FF, 18'h000FF, 18'h00000,
                                  18'h00001, 18'h00080, 1'b0, '0, '0, '0));
    // Sample right behind a write to the same pixel.
    dir_rows.push_back(write_row(0, 0, 16'h0001, 16'h0002, 16'h0003));
    dir_rows.push_back(sample_row(18'h00000, 18'h00000, 18'h00000, 18'h00000,
                                  18'h00000, 18'h00000, 1'b0, '0, '0, '0));
    dir_rows.push_back(write_row(255, 255, 16'h0000, 16'h0000, 16'h0000));
    dir_rows.push_back(sample_row(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
                                  18'h1FFFF, 18'h1FFFF, 1'b1, 16'h0000, 16'h0000, 16'h0000));

    foreach (dir_rows[i]) drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      no_idle = (p >= PHASES - 2);
      if (p < FIXED_PHASES) begin
        w_cfg = FIXED_W[p];
        h_cfg = FIXED_H[p];
      end else begin
        w_cfg = random_size();
        h_cfg = random_size();
      end
      write_sizes(w_cfg, h_cfg);
      build_axis(img_w, col_set, col_safe);
      build_axis(img_h, row_set, row_safe);

      // Fill the pixels this phase may sample. Pixels kept from earlier
      // phases, often written outside the image then in use, are mostly reused.
      foreach (col_set[i]) begin
        foreach (row_set[j]) begin
          x = col_set[i];
          y = row_set[j];
          if (!written[y * MAX_WIDTH + x] || $urandom_range(0, 3) == 0) begin
            it    = random_item();
            it.wx = COORD_W'(x);
            it.wy = COORD_W'(y);
            drive_item(it, 1'b0, '0);
          end
        end
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it = random_item();
        k  = $urandom_range(0, 19);
        if (k < 13) begin
          it.op = OP_SAMPLE;
          for (int c = 0; c < 3; c++) begin
            it.pos[2 * c]     = random_coord(img_w, col_safe);
            it.pos[2 * c + 1] = random_coord(img_h, row_safe);
          end
        end else if (k < 17) begin
          it.wx = COORD_W'(col_set[$urandom_range(0, col_set.size() - 1)]);
          it.wy = COORD_W'(row_set[$urandom_range(0, row_set.size() - 1)]);
        end
        drive_item(it, 1'b0, '0);
      end
      settle();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
